[rtl/vt4_pkg.sv]
// Shared types and constants for the 4x4 vector transform unit.
package vt4_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int N_LANES       = 4;
	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int SUM_W         = PROD_W + 2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_XFORM = 1'b1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [N_LANES-1:0] quad_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} lane_ctl_t;

endpackage

[rtl/vt4_lane.sv]
// One row lane: four products, their full-width sum, floor shift and saturation.
module vt4_lane #(
	parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  vt4_pkg::lane_ctl_t ctl,
	input  vt4_pkg::quad_t    coeffs,
	input  vt4_pkg::quad_t    vec,
	output vt4_pkg::word_t    res,
	output logic              sat
);
	import vt4_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [N_LANES];
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [SUM_W-1:0]  shifted;
	logic                     fits;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int i = 0; i < N_LANES; i++) begin
				prod_s1[i] <= $signed(coeffs[i]) * $signed(vec[i]);
			end
		end
		if (ctl.en_s2) begin
			sum_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1])
				+ SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
		end
	end

	always_comb begin
		shifted = sum_s2 >>> FRAC_BITS;
		fits    = (&shifted[SUM_W-1:WORD_W-1]) || !(|shifted[SUM_W-1:WORD_W-1]);
		sat     = !fits;
		if (fits) begin
			res = shifted[WORD_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			res = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end

endmodule

[rtl/vt4_merge.sv]
// Output register: gathers the four lane results and merges their clip flags.
module vt4_merge (
	input  logic           clk,
	input  logic           en,
	input  vt4_pkg::quad_t lane_res,
	input  logic [3:0]     lane_sat,
	output vt4_pkg::word_t out_x,
	output vt4_pkg::word_t out_y,
	output vt4_pkg::word_t out_z,
	output vt4_pkg::word_t out_w,
	output logic           saturated
);
	import vt4_pkg::*;

	word_t x_q, y_q, z_q, w_q;
	logic  sat_q;

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= lane_res[0];
			y_q   <= lane_res[1];
			z_q   <= lane_res[2];
			w_q   <= lane_res[3];
			sat_q <= |lane_sat;
		end
	end

	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_w     = w_q;
	assign saturated = sat_q;

endmodule

[rtl/vector_transform_4x4_unit.sv]
// Top level: coefficient matrix, four row lanes, pipeline control and output register.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-------------------------------------------------
//  request | req_valid | req_stall | req_type, row, col, coeff_value, vec_x..vec_w
//  result  | rsp_valid | rsp_stall | out_x, out_y, out_z, out_w, saturated
//
// One request word per cycle while req_stall is low. An accepted transform passes
// through the product, sum and output registers (products at accept, then the sum,
// then shift and saturate); the 32x32 lane multipliers and the full-width adder set
// the stage split. Coefficient writes take effect at accept and yield no result. Reset
// loads the identity matrix and empties the pipeline. Bubbles collapse; req_stall
// rises only when every stage holds a word.
module vector_transform_4x4_unit #(
	parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           req_type,
	input  logic [1:0]     row,
	input  logic [1:0]     col,
	input  vt4_pkg::word_t coeff_value,
	input  vt4_pkg::word_t vec_x,
	input  vt4_pkg::word_t vec_y,
	input  vt4_pkg::word_t vec_z,
	input  vt4_pkg::word_t vec_w,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vt4_pkg::word_t out_x,
	output vt4_pkg::word_t out_y,
	output vt4_pkg::word_t out_z,
	output vt4_pkg::word_t out_w,
	output logic           saturated
);
	import vt4_pkg::*;

	localparam word_t ONE = word_t'(1) << FRAC_BITS;

	word_t     coeff_q [N_LANES*N_LANES];
	logic      v_s1, v_s2, out_valid_q;
	logic      accept, adv_out, adv1, adv2;
	lane_ctl_t ctl;
	quad_t     vec, lane_res;
	logic [3:0] lane_sat;

	assign adv_out   = !out_valid_q || !rsp_stall;
	assign adv2      = v_s2 && adv_out;
	assign adv1      = v_s1 && (!v_s2 || adv_out);
	assign req_stall = v_s1 && !(!v_s2 || adv_out);
	assign accept    = req_valid && !req_stall;
	assign ctl.en_s1 = accept && (req_type == REQ_XFORM);
	assign ctl.en_s2 = adv1;
	assign vec       = {vec_w, vec_z, vec_y, vec_x};
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_LANES*N_LANES; i++) begin
				coeff_q[i] <= (i % (N_LANES + 1) == 0) ? ONE : '0;
			end
		end else if (accept && (req_type == REQ_WRITE)) begin
			coeff_q[{row, col}] <= coeff_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar r = 0; r < N_LANES; r++) begin : g_lane
		quad_t row_c;
		assign row_c = {coeff_q[r*N_LANES+3], coeff_q[r*N_LANES+2],
			coeff_q[r*N_LANES+1], coeff_q[r*N_LANES]};
		vt4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.coeffs (row_c),
			.vec    (vec),
			.res    (lane_res[r]),
			.sat    (lane_sat[r])
		);
	end

	vt4_merge u_merge (
		.clk       (clk),
		.en        (adv2),
		.lane_res  (lane_res),
		.lane_sat  (lane_sat),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated)
	);

`ifndef SYNTHESIS
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && v_s2 && out_valid_q))
		else $error("request stalled with a free stage");
	a_write_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_WRITE) && !v_s1) |=> !v_s1)
		else $error("coefficient write entered the pipeline");
	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_WRITE)) |=> (coeff_q[$past({row, col})] == $past(coeff_value)))
		else $error("coefficient write lost");
	a_s2_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> rsp_valid)
		else $error("sum stage advanced without a result");
`endif

endmodule

[bench/vt4_checker.sv]
// Checker for the 4x4 vector transform unit: tracks the matrix, predicts and compares results.
module vt4_checker #(
	parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  logic           req_type,
	input  logic  [1:0]    row,
	input  logic  [1:0]    col,
	input  vt4_pkg::word_t coeff_value,
	input  vt4_pkg::word_t vec_x,
	input  vt4_pkg::word_t vec_y,
	input  vt4_pkg::word_t vec_z,
	input  vt4_pkg::word_t vec_w,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  vt4_pkg::word_t out_x,
	input  vt4_pkg::word_t out_y,
	input  vt4_pkg::word_t out_z,
	input  vt4_pkg::word_t out_w,
	input  logic           saturated,
	output int             n_fail,
	output int             n_pending
);
	import vt4_pkg::*;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
		logic  sat;
	} xform_result_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 66'sd2147483647;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -66'sd2147483648;

	word_t         coeff_m [16];
	xform_result_t expected_q [$];
	xform_result_t got;
	xform_result_t want;

	// floor(sum of row products / 2^FRAC_BITS), clipped to 32 bits
	function automatic xform_result_t transform_vector(input word_t vx, vy, vz, vw);
		word_t                     v [4];
		word_t                     res [4];
		logic signed [PROD_W-1:0]  prod;
		logic signed [SUM_W-1:0]   acc;
		logic                      sat;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		v[3] = vw;
		sat  = 1'b0;
		for (int r = 0; r < 4; r++) begin
			acc = '0;
			for (int c = 0; c < 4; c++) begin
				prod = coeff_m[r*4+c] * v[c];
				acc  = acc + prod;
			end
			acc = acc >>> FRAC_BITS;
			if (acc > SUM_MAX) begin
				res[r] = 32'h7FFF_FFFF;
				sat    = 1'b1;
			end else if (acc < SUM_MIN) begin
				res[r] = 32'h8000_0000;
				sat    = 1'b1;
			end else begin
				res[r] = acc[WORD_W-1:0];
			end
		end
		return '{res[0], res[1], res[2], res[3], sat};
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				coeff_m[i] = (i % 5 == 0) ? word_t'(1 << FRAC_BITS) : '0;
			expected_q.delete();
			n_pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = '{out_x, out_y, out_z, out_w, saturated};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word: expected none, actual %h %h %h %h sat=%b",
						$time, out_x, out_y, out_z, out_w, saturated);
					n_fail++;
				end else begin
					want = expected_q.pop_front();
					check_field("out_x", want.x, got.x);
					check_field("out_y", want.y, got.y);
					check_field("out_z", want.z, got.z);
					check_field("out_w", want.w, got.w);
					check_field("saturated", 32'(want.sat), 32'(got.sat));
				end
			end
			if (req_valid && !req_stall) begin
				if (req_type == REQ_WRITE)
					coeff_m[{row, col}] = coeff_value;
				else
					expected_q.push_back(transform_vector(vec_x, vec_y, vec_z, vec_w));
			end
			n_pending = expected_q.size();
		end
	end

endmodule

[bench/tb_vector_transform_4x4_unit.sv]
// Testbench top for the 4x4 vector transform unit: stimulus, flow control and verdict.
module tb_vector_transform_4x4_unit;
	import vt4_pkg::*;

	localparam int    N_RANDOM    = 1100;
	localparam int    CYCLE_LIMIT = 200000;
	localparam word_t W_MAX       = 32'sh7FFF_FFFF;
	localparam word_t W_MIN       = 32'sh8000_0000;
	localparam word_t W_ONE       = 32'sh0001_0000;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic       req_type;
	logic [1:0] row;
	logic [1:0] col;
	word_t      coeff_value;
	word_t      vec_x;
	word_t      vec_y;
	word_t      vec_z;
	word_t      vec_w;
	logic       rsp_valid;
	logic       rsp_stall;
	word_t      out_x;
	word_t      out_y;
	word_t      out_z;
	word_t      out_w;
	logic       saturated;
	int         n_fail;
	int         n_pending;
	bit         idle_on;

	vector_transform_4x4_unit #(.FRAC_BITS(FRAC_BITS_DEF)) u_dut (.*);

	vt4_checker #(.FRAC_BITS(FRAC_BITS_DEF)) u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int n_cyc;
		n_cyc = 0;
		forever begin
			@(posedge clk);
			n_cyc++;
			if (n_cyc > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Q16.16 values: mostly small, some wide, some full range and extremes
	function automatic word_t rand_q();
		word_t v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			5:             v = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
			6, 7:          v = $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0:       v = W_MAX;
					1:       v = W_MIN;
					2:       v = '0;
					3:       v = 32'sd1;
					default: v = -32'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_word(input logic typ, input logic [1:0] r, c,
			input word_t cf, x, y, z, w);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type    = typ;
		row         = r;
		col         = c;
		coeff_value = cf;
		vec_x       = x;
		vec_y       = y;
		vec_z       = z;
		vec_w       = w;
		req_valid   = 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// receiver: random stall bursts plus one long hold-off to back up the pipeline
	initial begin
		int n_cyc;
		int burst;
		bit held;
		rsp_stall = 1'b0;
		n_cyc     = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n_cyc++;
			if (!held && n_cyc >= 600) begin
				held      = 1'b1;
				rsp_stall = 1'b1;
				repeat (80) @(negedge clk);
				rsp_stall = 1'b0;
				n_cyc += 80;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst     = $urandom_range(1, 12);
				rsp_stall = 1'b1;
				repeat (burst) @(negedge clk);
				rsp_stall = 1'b0;
				n_cyc += burst;
			end
		end
	end

	initial begin
		logic is_write;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_type    = REQ_XFORM;
		row         = '0;
		col         = '0;
		coeff_value = '0;
		vec_x       = '0;
		vec_y       = '0;
		vec_z       = '0;
		vec_w       = '0;
		idle_on     = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity matrix after reset; row/col/coeff on a transform are don't-care
		send_word(REQ_XFORM, 2'd0, 2'd0, '0, W_MAX, W_MIN, '0, -32'sd1);
		send_word(REQ_XFORM, 2'd3, 2'd3, W_MAX, 32'sd1, -32'sd1, W_ONE, W_MIN);
		// row 0 all max, row 1 all min, row 2 small mix, row 3 stays identity
		for (int c = 0; c < 4; c++)
			send_word(REQ_WRITE, 2'd0, 2'(c), W_MAX, $urandom, $urandom, $urandom, $urandom);
		for (int c = 0; c < 4; c++)
			send_word(REQ_WRITE, 2'd1, 2'(c), W_MIN, $urandom, $urandom, $urandom, $urandom);
		send_word(REQ_WRITE, 2'd2, 2'd0, W_ONE, W_MAX, W_MAX, W_MAX, W_MAX);
		send_word(REQ_WRITE, 2'd2, 2'd1, -W_ONE, W_MIN, W_MIN, W_MIN, W_MIN);
		send_word(REQ_WRITE, 2'd2, 2'd2, '0, '0, '0, '0, '0);
		send_word(REQ_WRITE, 2'd2, 2'd3, 32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_word(REQ_XFORM, 2'd1, 2'd2, $urandom, W_MAX, W_MAX, W_MAX, W_MAX);
		send_word(REQ_XFORM, 2'd2, 2'd1, $urandom, W_MIN, W_MIN, W_MIN, W_MIN);
		send_word(REQ_XFORM, 2'd0, 2'd0, '0, '0, '0, '0, '0);
		send_word(REQ_XFORM, 2'd0, 2'd0, '0, '0, '0, '0, -32'sd1);
		send_word(REQ_XFORM, 2'd0, 2'd0, '0, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
		send_word(REQ_XFORM, 2'd3, 2'd0, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);

		for (int i = 0; i < N_RANDOM; i++) begin
			idle_on  = (i < N_RANDOM - 150) && ((i / 100) % 3 != 2);
			is_write = ($urandom_range(0, 3) == 0);
			if (is_write)
				send_word(REQ_WRITE, 2'($urandom), 2'($urandom), rand_q(),
					$urandom, $urandom, $urandom, $urandom);
			else
				send_word(REQ_XFORM, 2'($urandom), 2'($urandom), $urandom,
					rand_q(), rand_q(), rand_q(), rand_q());
		end

		@(negedge clk);
		req_valid = 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (n_fail == 0 && n_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/vt4_pkg.sv
rtl/vt4_lane.sv
rtl/vt4_merge.sv
rtl/vector_transform_4x4_unit.sv
bench/vt4_checker.sv
bench/tb_vector_transform_4x4_unit.sv
